// ===== hdl/apf_pkg.sv =====
// apf_pkg: shared types, constants and byte/CRC helpers for the audio packet framer.
// No dependencies; used by apf_front, apf_queue, apf_back and the top level.
package apf_pkg;

  // Configuration register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_CHANNEL_COUNT = 3'd0,
    REG_FRAMES        = 3'd1,
    REG_SOURCE_ID     = 3'd2,
    REG_START_SEQ     = 3'd3,
    REG_START_TS      = 3'd4
  } reg_idx_t;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  localparam logic [7:0] RTP_VER_BYTE = 8'h80;
  localparam logic [7:0] RTP_PT_BYTE  = 8'd96;
  localparam logic [7:0] MAGIC_0      = 8'h4F;
  localparam logic [7:0] MAGIC_1      = 8'h53;
  localparam logic [7:0] MAGIC_2      = 8'h54;
  localparam logic [7:0] MAGIC_3      = 8'h50;

  localparam logic [3:0]  CH_RESET  = 4'd2;
  localparam logic [3:0]  CH_MIN    = 4'd1;
  localparam logic [10:0] FR_RESET  = 11'd480;
  localparam logic [10:0] FR_MIN    = 11'd48;
  localparam logic [10:0] FR_MAX    = 11'd1024;

  localparam logic signed [25:0] SAMPLE_MAX = 26'sd8388608;
  localparam logic signed [25:0] SAMPLE_MIN = -26'sd8388608;

  // Byte positions within one command's byte run
  localparam logic [5:0] POS_SAMPLE   = 6'd32;
  localparam logic [5:0] POS_CRC      = 6'd36;
  localparam logic [5:0] POS_END_DATA = 6'd35;
  localparam logic [5:0] POS_END_CRC  = 6'd39;

  // One accepted sample, with everything the back end needs to emit its bytes
  typedef struct packed {
    logic        first;
    logic        last;
    logic [31:0] word;
    logic [15:0] seq;
    logic [31:0] rtp;
    logic [31:0] ssrc;
    logic [3:0]  chan;
    logic [31:0] media;
  } cmd_t;

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // RTP header (12 bytes) followed by stream header (20 bytes)
  function automatic logic [7:0] header_byte(input logic [4:0] pos, input cmd_t c);
    logic [7:0] b;
    case (pos)
      5'd0:  b = RTP_VER_BYTE;
      5'd1:  b = RTP_PT_BYTE;
      5'd2:  b = c.seq[15:8];
      5'd3:  b = c.seq[7:0];
      5'd4:  b = c.rtp[31:24];
      5'd5:  b = c.rtp[23:16];
      5'd6:  b = c.rtp[15:8];
      5'd7:  b = c.rtp[7:0];
      5'd8:  b = c.ssrc[31:24];
      5'd9:  b = c.ssrc[23:16];
      5'd10: b = c.ssrc[15:8];
      5'd11: b = c.ssrc[7:0];
      5'd12: b = MAGIC_0;
      5'd13: b = MAGIC_1;
      5'd14: b = MAGIC_2;
      5'd15: b = MAGIC_3;
      5'd16: b = {c.chan, 4'h0};
      5'd20: b = c.ssrc[31:24];
      5'd21: b = c.ssrc[23:16];
      5'd22: b = c.ssrc[15:8];
      5'd23: b = c.ssrc[7:0];
      5'd28: b = c.media[31:24];
      5'd29: b = c.media[23:16];
      5'd30: b = c.media[15:8];
      5'd31: b = c.media[7:0];
      default: b = 8'h00;  // sequence extension and flags
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/apf_front.sv =====
// apf_front: configuration registers, sample accept, clamp and packet position tracking.
// Depends on apf_pkg; feeds commands into apf_queue.
module apf_front #(
  parameter int unsigned TIMESTAMP_STEP = 480
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [63:0]       in_tdata,   // [25:0] sample, [57:26] media_time
  // to queue
  output logic              q_push,
  output apf_pkg::cmd_t     q_cmd,
  input  logic              q_full
);

  logic [3:0]  chan_r;
  logic [10:0] frames_r;
  logic [31:0] ssrc_r;
  logic [15:0] start_seq_r;
  logic [31:0] start_ts_r;
  logic [15:0] seq_r, seq_nxt;
  logic [31:0] rtp_r, rtp_nxt;
  logic [13:0] idx_r, idx_nxt;

  logic              cfg_wr;
  apf_pkg::reg_idx_t cfg_idx;
  logic              in_fire;
  logic [3:0]        ch_sat;
  logic [10:0]       fr_sat;
  logic [14:0]       total;
  logic              is_last;
  logic signed [25:0] smp;
  logic signed [25:0] smp_clamp;

  assign cfg_wr  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx = apf_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      apf_pkg::REG_CHANNEL_COUNT: cfg_prdata = {28'h0, chan_r};
      apf_pkg::REG_FRAMES:        cfg_prdata = {21'h0, frames_r};
      apf_pkg::REG_SOURCE_ID:     cfg_prdata = ssrc_r;
      apf_pkg::REG_START_SEQ:     cfg_prdata = {16'h0, start_seq_r};
      apf_pkg::REG_START_TS:      cfg_prdata = start_ts_r;
      default:                    cfg_prdata = 32'h0;
    endcase
  end

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  // geometry saturates to the legal range
  always_comb begin
    ch_sat = (chan_r < apf_pkg::CH_MIN) ? apf_pkg::CH_MIN : chan_r;
    if (frames_r < apf_pkg::FR_MIN) begin
      fr_sat = apf_pkg::FR_MIN;
    end else if (frames_r > apf_pkg::FR_MAX) begin
      fr_sat = apf_pkg::FR_MAX;
    end else begin
      fr_sat = frames_r;
    end
    total   = 15'(fr_sat) * 15'(ch_sat);
    is_last = ({1'b0, idx_r} + 15'd1) >= total;
  end

  always_comb begin
    smp = $signed(in_tdata[25:0]);
    if (smp > apf_pkg::SAMPLE_MAX) begin
      smp_clamp = apf_pkg::SAMPLE_MAX;
    end else if (smp < apf_pkg::SAMPLE_MIN) begin
      smp_clamp = apf_pkg::SAMPLE_MIN;
    end else begin
      smp_clamp = smp;
    end
  end

  always_comb begin
    q_cmd.first = (idx_r == 14'd0);
    q_cmd.last  = is_last;
    q_cmd.word  = {{6{smp_clamp[25]}}, smp_clamp};
    q_cmd.seq   = seq_r;
    q_cmd.rtp   = rtp_r;
    q_cmd.ssrc  = ssrc_r;
    q_cmd.chan  = ch_sat;
    q_cmd.media = in_tdata[57:26];
  end
  assign q_push = in_fire;

  always_comb begin
    seq_nxt = seq_r;
    rtp_nxt = rtp_r;
    idx_nxt = idx_r;
    if (in_fire) begin
      if (is_last) begin
        idx_nxt = 14'd0;
        seq_nxt = seq_r + 16'd1;
        rtp_nxt = rtp_r + 32'(TIMESTAMP_STEP);
      end else begin
        idx_nxt = idx_r + 14'd1;
      end
    end
    // start registers load the live counters at once
    if (cfg_wr && cfg_idx == apf_pkg::REG_START_SEQ) begin
      seq_nxt = cfg_pwdata[15:0];
    end
    if (cfg_wr && cfg_idx == apf_pkg::REG_START_TS) begin
      rtp_nxt = cfg_pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= apf_pkg::CH_RESET;
      frames_r    <= apf_pkg::FR_RESET;
      ssrc_r      <= 32'h0;
      start_seq_r <= 16'h0;
      start_ts_r  <= 32'h0;
      seq_r       <= 16'h0;
      rtp_r       <= 32'h0;
      idx_r       <= 14'd0;
    end else begin
      seq_r <= seq_nxt;
      rtp_r <= rtp_nxt;
      idx_r <= idx_nxt;
      if (cfg_wr) begin
        case (cfg_idx)
          apf_pkg::REG_CHANNEL_COUNT: chan_r      <= cfg_pwdata[3:0];
          apf_pkg::REG_FRAMES:        frames_r    <= cfg_pwdata[10:0];
          apf_pkg::REG_SOURCE_ID:     ssrc_r      <= cfg_pwdata;
          apf_pkg::REG_START_SEQ:     start_seq_r <= cfg_pwdata[15:0];
          apf_pkg::REG_START_TS:      start_ts_r  <= cfg_pwdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== hdl/apf_queue.sv =====
// apf_queue: small command FIFO between the accept side and the byte serializer.
// Depends on apf_pkg for cmd_t.
module apf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  apf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output apf_pkg::cmd_t pop_cmd,
  output logic          not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  apf_pkg::cmd_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_cmd   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not follow push");
`endif

endmodule

// ===== hdl/apf_back.sv =====
// apf_back: turns queued commands into the packet byte stream and computes the CRC-32.
// Depends on apf_pkg; drains apf_queue and drives the registered output stage.
module apf_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  apf_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,   // [7:0] packet_byte
  output logic          out_tlast    // end_of_packet
);

  apf_pkg::cmd_t cur_r, cur_nxt;
  logic          cur_vld_r, cur_vld_nxt;
  logic [5:0]    pos_r, pos_nxt;
  logic [31:0]   crc_r, crc_nxt;
  logic          ovld_r, ovld_nxt;
  logic [7:0]    obyte_r, obyte_nxt;
  logic          olast_r, olast_nxt;

  logic          load;
  logic          at_end;
  logic [5:0]    end_pos;
  logic [7:0]    byte_sel;
  logic [31:0]   crc_fin;
  logic [31:0]   crc_base;

  assign end_pos = cur_r.last ? apf_pkg::POS_END_CRC : apf_pkg::POS_END_DATA;
  assign load    = cur_vld_r && (!ovld_r || out_tready);
  assign at_end  = (pos_r == end_pos);
  assign q_pop   = q_valid && (!cur_vld_r || (load && at_end));
  assign crc_fin = crc_r ^ apf_pkg::CRC_ONES;
  // header byte 0 restarts the CRC
  assign crc_base = (pos_r == 6'd0) ? apf_pkg::CRC_ONES : crc_r;

  always_comb begin
    if (pos_r < apf_pkg::POS_SAMPLE) begin
      byte_sel = apf_pkg::header_byte(pos_r[4:0], cur_r);
    end else if (pos_r < apf_pkg::POS_CRC) begin
      byte_sel = 8'(cur_r.word >> {pos_r[1:0], 3'b000});
    end else begin
      byte_sel = 8'(crc_fin >> {pos_r[1:0], 3'b000});
    end
  end

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    ovld_nxt    = ovld_r;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    if (out_tready) begin
      ovld_nxt = 1'b0;
    end
    if (load) begin
      ovld_nxt  = 1'b1;
      obyte_nxt = byte_sel;
      olast_nxt = cur_r.last && (pos_r == apf_pkg::POS_END_CRC);
      pos_nxt   = pos_r + 6'd1;
      if (pos_r < apf_pkg::POS_CRC) begin
        crc_nxt = apf_pkg::crc_byte(crc_base, byte_sel);
      end else if (pos_r == apf_pkg::POS_END_CRC) begin
        crc_nxt = apf_pkg::CRC_ONES;
      end
      if (at_end) begin
        cur_vld_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      cur_nxt     = q_cmd;
      cur_vld_nxt = 1'b1;
      pos_nxt     = q_cmd.first ? 6'd0 : apf_pkg::POS_SAMPLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      pos_r     <= 6'd0;
      crc_r     <= apf_pkg::CRC_ONES;
      ovld_r    <= 1'b0;
      olast_r   <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      ovld_r    <= ovld_nxt;
      olast_r   <= olast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r && ovld_r;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_vld_r |-> pos_r <= end_pos)
    else $error("byte position past end of command");
  a_mid_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_vld_r && !cur_r.first) |-> pos_r >= apf_pkg::POS_SAMPLE)
    else $error("header bytes on a non-first sample");
  a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (load && pos_r == apf_pkg::POS_END_CRC) |=> crc_r == apf_pkg::CRC_ONES)
    else $error("CRC not restarted after packet end");
  a_pop_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_vld_r && !(load && at_end)) |-> !q_pop)
    else $error("command popped while current one busy");
`endif

endmodule

// ===== hdl/audio_packet_framer_crc32_unit.sv =====
// Audio packet framer with CRC-32.
// Input stream: one sample per transaction, in_tdata [25:0] sample (signed, 23 fraction
//   bits), [57:26] media_time (used on the first sample of a packet).
// Output stream: one packet byte per transaction on out_tdata; out_tlast marks the last
//   CRC byte. Each packet is a 12-byte RTP header, a 20-byte stream header, the samples
//   clamped to +/-2^23 as little-endian int32, then the CRC-32 of all prior bytes (LE).
// Config: APB-style port, registers at byte address 4*i: channel_count, frames_per_packet,
//   source_id, start_sequence, start_timestamp. Writing a start register also loads the
//   live sequence or timestamp.
// Throughput: one byte per cycle unless out_tready stalls; a sample is 4 bytes, the
//   first of a packet 36 and the last 8. A command queue of QUEUE_DEPTH entries lets
//   the input keep accepting while earlier samples are still being serialized.
// Path: queue, then current-command register, then output register.
// Reset: registers go to their reset values, queue and output stage empty, CRC all ones.
// When out_tready is low the output byte holds; the queue fills and in_tready drops.
// Depends on apf_pkg, apf_front, apf_queue, apf_back.
module audio_packet_framer_crc32_unit #(
  parameter int unsigned TIMESTAMP_STEP = 480,
  parameter int unsigned QUEUE_DEPTH    = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [25:0] sample, [57:26] media_time
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] packet_byte
  output logic        out_tlast    // end_of_packet
);

  logic          q_push, q_full, q_pop, q_valid;
  apf_pkg::cmd_t push_cmd, pop_cmd;

  assign cfg_pready = 1'b1;

  apf_front #(
    .TIMESTAMP_STEP(TIMESTAMP_STEP)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .q_push     (q_push),
    .q_cmd      (push_cmd),
    .q_full     (q_full)
  );

  apf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .not_empty(q_valid)
  );

  apf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule
